FILE: hw/rtl/conv1d_channel_group_mac_assert.svh
// assertion macros shared by the checker file
`ifndef CONV1D_CHANNEL_GROUP_MAC_ASSERT_SVH
`define CONV1D_CHANNEL_GROUP_MAC_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CGM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cgm check failed");

// next-cycle implication, sampled on clk, off during reset
`define CGM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cgm check failed");

`endif

FILE: hw/rtl/cgm_pkg.sv
// shared constants, types and functions for the conv1d channel group mac
`timescale 1ns / 1ps

package cgm_pkg;

    localparam int KERNEL_TAPS_DEF  = 19;
    localparam int IN_CHANNELS_DEF  = 16;
    localparam int OUT_CHANNELS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 13;
    localparam int VALUE_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 41;
    localparam int CHAN_W   = 4;

    localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    localparam logic signed [VALUE_W-1:0] SAT_MAX = 32'sd32767;
    localparam logic signed [VALUE_W-1:0] SAT_MIN = -32'sd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    // write broadcast from the input port to the stores
    typedef struct packed {
        logic                        weight_en;
        logic                        bias_en;
        logic                        sample_en;
        logic [ADDR_W-1:0]           addr;
        logic signed [VALUE_W-1:0]   value;
        logic signed [SAMPLE_W-1:0]  sample;
    } wr_t;

    // window sample traveling down the row of cells
    typedef struct packed {
        logic                        valid;
        logic                        first;
        logic                        last;
        logic [ADDR_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0]  sample;
    } token_t;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [VALUE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/cgm_if.sv
// valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps

interface cgm_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [cgm_pkg::CMD_W-1:0]              command;
    logic [cgm_pkg::ADDR_W-1:0]             address;
    logic signed [cgm_pkg::VALUE_W-1:0]     value;

    modport source (output valid, output command, output address, output value, input ready);
    modport sink (input valid, input command, input address, input value, output ready);
endinterface

interface cgm_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [cgm_pkg::CHAN_W-1:0]             out_channel;
    logic signed [cgm_pkg::ACC_W-1:0]       out_value;
    logic                                   last;

    modport source (output valid, output out_channel, output out_value, output last, input ready);
    modport sink (input valid, input out_channel, input out_value, input last, output ready);
endinterface

FILE: hw/rtl/conv1d_channel_group_mac.sv
// Top level: one 1-D convolution tile, a row of channel mac cells fed by the window store.
// Weight, bias and non-final sample words are taken while idle and produce no result.
// The final window sample starts a run: samples stream one per cycle down the cell row;
// after the last cell, OUT_CHANNELS result words follow one per cycle while out.ready holds.
// Reset clears control and the accumulators; weight, bias and window stores are unset.
`timescale 1ns / 1ps

module conv1d_channel_group_mac #(
    parameter int KERNEL_TAPS  = cgm_pkg::KERNEL_TAPS_DEF,
    parameter int IN_CHANNELS  = cgm_pkg::IN_CHANNELS_DEF,
    parameter int OUT_CHANNELS = cgm_pkg::OUT_CHANNELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cgm_in_if.sink     in,
    cgm_out_if.source  out
);
    import cgm_pkg::*;

    localparam int WIN_LEN = KERNEL_TAPS * IN_CHANNELS;
    localparam int W_LEN   = OUT_CHANNELS * WIN_LEN;
    localparam int CW      = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam logic [CW-1:0] LAST_CH = CW'(OUT_CHANNELS - 1);

    state_t                  state_reg;
    state_t                  state_next;
    logic [CW-1:0]           emit_idx_reg;
    logic [CW-1:0]           emit_idx_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [CHAN_W-1:0]       out_channel_reg;
    logic [CHAN_W-1:0]       out_channel_next;
    logic signed [ACC_W-1:0] out_value_reg;
    logic signed [ACC_W-1:0] out_value_next;
    logic                    out_last_reg;
    logic                    out_last_next;
    logic                    load_out;

    logic                    accept;
    logic                    trigger;
    wr_t                     wr;
    token_t                  tok_chain [OUT_CHANNELS+1];
    logic signed [ACC_W-1:0] acc_w [OUT_CHANNELS];
    logic                    done_w [OUT_CHANNELS];

    assign in.ready = (state_reg == ST_IDLE);
    assign accept   = in.valid && in.ready;

    always_comb
    begin
        wr.weight_en = accept && (in.command == CMD_WEIGHT) && (int'(in.address) < W_LEN);
        wr.bias_en   = accept && (in.command == CMD_BIAS) && (int'(in.address) < OUT_CHANNELS);
        wr.sample_en = accept && (in.command == CMD_SAMPLE) && (int'(in.address) < WIN_LEN);
        wr.addr      = in.address;
        wr.value     = in.value;
        wr.sample    = sat16(in.value);
    end

    assign trigger = wr.sample_en && (int'(in.address) == WIN_LEN - 1);

    cgm_window #(
        .WIN_LEN(WIN_LEN)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .start (trigger),
        .tok   (tok_chain[0])
    );

    for (genvar k = 0; k < OUT_CHANNELS; k++)
    begin : g_cell
        cgm_cell #(
            .WIN_LEN(WIN_LEN),
            .INDEX  (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .tok_in  (tok_chain[k]),
            .tok_out (tok_chain[k+1]),
            .acc     (acc_w[k]),
            .done    (done_w[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_channel_reg <= out_channel_next;
        out_value_reg   <= out_value_next;
        out_last_reg    <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        emit_idx_next    = emit_idx_reg;
        out_valid_next   = out_valid_reg && !out.ready;
        out_channel_next = out_channel_reg;
        out_value_next   = out_value_reg;
        out_last_next    = out_last_reg;
        load_out         = !out_valid_reg || out.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (trigger)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (done_w[OUT_CHANNELS-1])
                begin
                    state_next    = ST_EMIT;
                    emit_idx_next = '0;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next   = 1'b1;
                    out_channel_next = CHAN_W'(emit_idx_reg);
                    out_value_next   = acc_w[emit_idx_reg];
                    out_last_next    = (emit_idx_reg == LAST_CH);
                    if (emit_idx_reg == LAST_CH)
                    begin
                        state_next    = ST_IDLE;
                        emit_idx_next = '0;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out.valid       = out_valid_reg;
    assign out.out_channel = out_channel_reg;
    assign out.out_value   = out_value_reg;
    assign out.last        = out_last_reg;

endmodule

FILE: hw/rtl/cgm_window.sv
// window sample store and the feeder that streams it into the cell row
`timescale 1ns / 1ps

module cgm_window #(
    parameter int WIN_LEN = cgm_pkg::KERNEL_TAPS_DEF * cgm_pkg::IN_CHANNELS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cgm_pkg::wr_t     wr,
    input  logic             start,
    output cgm_pkg::token_t  tok
);
    import cgm_pkg::*;

    localparam int WA = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam logic [WA-1:0] LAST_IDX = WA'(WIN_LEN - 1);

    logic signed [SAMPLE_W-1:0] mem [WIN_LEN];
    logic signed [SAMPLE_W-1:0] sample_rd_reg;
    logic [WA-1:0]              rd_idx_reg;
    logic                       rd_active_reg;
    logic                       tok_valid_reg;
    logic                       tok_first_reg;
    logic                       tok_last_reg;
    logic [WA-1:0]              tok_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr.sample_en)
        begin
            mem[wr.addr[WA-1:0]] <= wr.sample;
        end
        sample_rd_reg <= mem[rd_idx_reg];
        tok_idx_reg   <= rd_idx_reg;
        tok_first_reg <= (rd_idx_reg == '0);
        tok_last_reg  <= (rd_idx_reg == LAST_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_active_reg <= 1'b0;
            rd_idx_reg    <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= rd_active_reg;
            if (start)
            begin
                rd_active_reg <= 1'b1;
                rd_idx_reg    <= '0;
            end
            else if (rd_active_reg)
            begin
                if (rd_idx_reg == LAST_IDX)
                begin
                    rd_active_reg <= 1'b0;
                    rd_idx_reg    <= '0;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        tok.valid  = tok_valid_reg;
        tok.first  = tok_first_reg;
        tok.last   = tok_last_reg;
        tok.addr   = ADDR_W'(tok_idx_reg);
        tok.sample = sample_rd_reg;
    end

endmodule

FILE: hw/rtl/cgm_cell.sv
// one output channel: weight row, bias and multiply-accumulate
`timescale 1ns / 1ps

module cgm_cell #(
    parameter int WIN_LEN = cgm_pkg::KERNEL_TAPS_DEF * cgm_pkg::IN_CHANNELS_DEF,
    parameter int INDEX   = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cgm_pkg::wr_t                       wr,
    input  cgm_pkg::token_t                    tok_in,
    output cgm_pkg::token_t                    tok_out,
    output logic signed [cgm_pkg::ACC_W-1:0]   acc,
    output logic                               done
);
    import cgm_pkg::*;

    localparam int WA = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam int LO = INDEX * WIN_LEN;
    localparam int HI = LO + WIN_LEN;

    logic signed [SAMPLE_W-1:0] wmem [WIN_LEN];
    logic signed [SAMPLE_W-1:0] w_rd_reg;
    logic signed [VALUE_W-1:0]  bias_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    token_t                     tok_reg;
    logic                       p_valid_reg;
    logic                       p_first_reg;
    logic                       p_last_reg;
    logic                       done_reg;
    logic                       w_hit;
    logic [WA-1:0]              w_off;
    logic signed [ACC_W-1:0]    acc_base;

    assign w_hit = wr.weight_en && (int'(wr.addr) >= LO) && (int'(wr.addr) < HI);
    assign w_off = WA'(int'(wr.addr) - LO);

    always_ff @(posedge clk)
    begin
        if (w_hit)
        begin
            wmem[w_off] <= wr.sample;
        end
        if (wr.bias_en && (int'(wr.addr) == INDEX))
        begin
            bias_reg <= wr.value;
        end
        w_rd_reg    <= wmem[tok_in.addr[WA-1:0]];
        prod_reg    <= tok_reg.sample * w_rd_reg;
        p_first_reg <= tok_reg.first;
        p_last_reg  <= tok_reg.last;
    end

    assign acc_base = p_first_reg ? ACC_W'(bias_reg) : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg     <= '0;
            p_valid_reg <= 1'b0;
            acc_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            tok_reg     <= tok_in;
            p_valid_reg <= tok_reg.valid;
            done_reg    <= p_valid_reg && p_last_reg;
            if (p_valid_reg)
            begin
                acc_reg <= acc_base + ACC_W'(prod_reg);
            end
        end
    end

    assign tok_out = tok_reg;
    assign acc     = acc_reg;
    assign done    = done_reg;

endmodule

FILE: hw/rtl/cgm_checker.sv
// port-level checker for the conv1d channel group mac, with its bind
`timescale 1ns / 1ps

`include "conv1d_channel_group_mac_assert.svh"

module cgm_checker #(
    parameter int OUT_CHANNELS = cgm_pkg::OUT_CHANNELS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [cgm_pkg::CHAN_W-1:0]        out_channel,
    input logic signed [cgm_pkg::ACC_W-1:0]  out_value,
    input logic                              out_last
);
    import cgm_pkg::*;

    localparam logic [CHAN_W-1:0] LAST_CH = CHAN_W'(OUT_CHANNELS - 1);

    // a stalled result word holds its payload
    `CGM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_channel) && $stable(out_last))

    // last flag only on the final channel
    `CGM_ASSERT_NOW(a_last_chan, out_valid && out_last, out_channel == LAST_CH)

    // input stays closed while a run still has words to deliver
    `CGM_ASSERT_NOW(a_no_input_mid_run, out_valid && !out_last, !in_ready)

    // words of one run come back to back once taken
    `CGM_ASSERT_NEXT(a_run_contiguous, out_valid && out_ready && !out_last, out_valid)

endmodule

bind conv1d_channel_group_mac cgm_checker #(
    .OUT_CHANNELS(OUT_CHANNELS)
) u_cgm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in.ready),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .out_channel (out.out_channel),
    .out_value   (out.out_value),
    .out_last    (out.last)
);
